// ===== rtl/ooa_pkg.sv =====
// ooa_pkg: shared types and constants for the orientational order accumulator
// no dependencies
package ooa_pkg;

    localparam int ORDER_WIDTH = 18;
    localparam int COUNT_OUT_WIDTH = 16;

    typedef enum logic [1:0] {
        MODE_BOND_Z = 2'd0,
        MODE_RING_Z = 2'd1,
        MODE_RING_X = 2'd2,
        MODE_RING_Y = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUM,
        BK_DIV,
        BK_ACC,
        BK_AVG,
        BK_OUT
    } back_state_t;

endpackage

// ===== rtl/ooa_stream_if.sv =====
// ooa_stream_if: valid/ready channel carrying a payload of parameter type
// depends on nothing
interface ooa_stream_if #(
    parameter type PAYLOAD_T = logic
);
    logic     valid;
    logic     ready;
    PAYLOAD_T data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ooa_front.sv =====
// ooa_front: accepts items, forms the vector differences and the mode tag,
// writes them to a two-entry queue; depends on ooa_pkg and ooa_stream_if
module ooa_front #(
    parameter int COORD_WIDTH = 16,
    parameter type IN_T = logic,
    parameter type Q_T = logic
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ooa_pkg::mode_t  mode,
    ooa_stream_if.sink      in_ch,
    output logic            q_valid,
    output Q_T              q_data,
    input  logic            q_pop
);
    localparam int DW = COORD_WIDTH + 1;

    Q_T          mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fill_reg;
    Q_T          entry;
    logic        push;

    assign in_ch.ready = (fill_reg != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign q_valid = (fill_reg != 2'd0);
    assign q_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        entry.mode = mode;
        entry.last = in_ch.data.last;
        entry.d1 = DW'(in_ch.data.bx) - DW'(in_ch.data.ax);
        entry.d2 = DW'(in_ch.data.by) - DW'(in_ch.data.ay);
        entry.d3 = DW'(in_ch.data.bz) - DW'(in_ch.data.az);
        entry.e1 = DW'(in_ch.data.cx) - DW'(in_ch.data.ax);
        entry.e2 = DW'(in_ch.data.cy) - DW'(in_ch.data.ay);
        entry.e3 = DW'(in_ch.data.cz) - DW'(in_ch.data.az);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(q_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3) else $error("queue fill out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> fill_reg != 2'd0) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd2 && !q_pop) |=> fill_reg == 2'd2)
        else $error("full queue lost an entry");
`endif
endmodule

// ===== rtl/ooa_back.sv =====
// ooa_back: cross product (ring modes), squares, iterative Q.16 division, accumulation and
// iterative mean; depends on ooa_pkg and ooa_stream_if
module ooa_back #(
    parameter int COORD_WIDTH = 16,
    parameter int MAX_ITEMS = 65535,
    parameter type Q_T = logic,
    parameter type OUT_T = logic
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  Q_T          q_data,
    output logic        q_pop,
    ooa_stream_if.source out_ch
);
    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW + 1;          // cross component
    localparam int SW  = 2 * PW;              // square of component
    localparam int RW  = SW + 2;              // sum of three squares
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = CNT_W + 18;
    localparam int MAG_W = SUM_W;

    ooa_pkg::back_state_t state_reg, state_next;

    Q_T                     item_reg;
    logic signed [PW-1:0]   vx_reg, vy_reg, vz_reg;
    logic [RW-1:0]          r2_reg;
    logic [RW+1:0]          rem_reg;
    logic [16:0]            quo_reg;
    logic [4:0]             step_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   deg_reg;
    logic [MAG_W-1:0]       amag_reg;
    logic [MAG_W-1:0]       arem_reg;
    logic [MAG_W-1:0]       aquo_reg;
    logic                   aneg_reg;
    logic [5:0]             astep_reg;
    OUT_T                   out_reg;

    logic signed [PW-1:0]   sel;
    logic [PW-1:0]          sel_mag;
    logic [RW+1:0]          rem_sh;
    logic signed [19:0]     t3;
    logic signed [18:0]     term;
    logic [MAG_W:0]         arem_sh;
    logic signed [MAG_W:0]  avg_s;

    function automatic logic [SW-1:0] sq(input logic signed [PW-1:0] v);
        logic [PW-1:0] m;
        m = v[PW-1] ? PW'(-v) : PW'(v);
        return SW'(m) * SW'(m);
    endfunction

    always_comb
    begin
        case (item_reg.mode)
            ooa_pkg::MODE_RING_X: sel = vx_reg;
            ooa_pkg::MODE_RING_Y: sel = vy_reg;
            default:              sel = vz_reg;
        endcase
        sel_mag = sel[PW-1] ? PW'(-sel) : PW'(sel);
        rem_sh = {rem_reg[RW:0], 1'b0};
        t3 = 20'sd3 * $signed({3'b000, quo_reg}) - 20'sd65536;
        term = 19'(t3 >>> 1);
        arem_sh = {arem_reg, amag_reg[MAG_W-1]};
        avg_s = aneg_reg ? -$signed({1'b0, aquo_reg}) : $signed({1'b0, aquo_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ooa_pkg::BK_IDLE: if (q_valid) state_next = ooa_pkg::BK_MUL;
            ooa_pkg::BK_MUL:  state_next = ooa_pkg::BK_SUM;
            ooa_pkg::BK_SUM:
                // a zero-length vector runs the divider too, its quotient is dropped
                if (cnt_reg >= CNT_W'(MAX_ITEMS))
                    state_next = ooa_pkg::BK_ACC;
                else
                    state_next = ooa_pkg::BK_DIV;
            ooa_pkg::BK_DIV:  if (step_reg == 5'd16) state_next = ooa_pkg::BK_ACC;
            ooa_pkg::BK_ACC:
                if (item_reg.last) state_next = ooa_pkg::BK_AVG;
                else state_next = ooa_pkg::BK_IDLE;
            ooa_pkg::BK_AVG:
                if (astep_reg == 6'(MAG_W + 1)) state_next = ooa_pkg::BK_OUT;
            ooa_pkg::BK_OUT:  if (out_ch.ready) state_next = ooa_pkg::BK_IDLE;
            default:          state_next = ooa_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (state_reg == ooa_pkg::BK_IDLE) && q_valid;
        out_ch.valid = (state_reg == ooa_pkg::BK_OUT);
        out_ch.data = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ooa_pkg::BK_IDLE;
            sum_reg <= '0;
            cnt_reg <= '0;
            deg_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ooa_pkg::BK_ACC)
            begin
                if (r2_reg == '0)
                    deg_reg <= 1'b1;
                else if (cnt_reg < CNT_W'(MAX_ITEMS))
                begin
                    sum_reg <= sum_reg + SUM_W'(term);
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (state_reg == ooa_pkg::BK_OUT && out_ch.ready)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
                deg_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ooa_pkg::BK_IDLE:
                item_reg <= q_data;
            ooa_pkg::BK_MUL:
            begin
                if (item_reg.mode == ooa_pkg::MODE_BOND_Z)
                begin
                    vx_reg <= PW'(item_reg.d1);
                    vy_reg <= PW'(item_reg.d2);
                    vz_reg <= PW'(item_reg.d3);
                end
                else
                begin
                    vx_reg <= PW'(item_reg.d2 * item_reg.e3) - PW'(item_reg.d3 * item_reg.e2);
                    vy_reg <= PW'(item_reg.d3 * item_reg.e1) - PW'(item_reg.d1 * item_reg.e3);
                    vz_reg <= PW'(item_reg.d1 * item_reg.e2) - PW'(item_reg.d2 * item_reg.e1);
                end
            end
            ooa_pkg::BK_SUM:
            begin
                // one square per axis, the selected one recomputed as the numerator
                r2_reg <= RW'(sq(vx_reg)) + RW'(sq(vy_reg)) + RW'(sq(vz_reg));
                rem_reg <= (RW+2)'(sq($signed(sel_mag)));
                quo_reg <= '0;
                step_reg <= '0;
            end
            ooa_pkg::BK_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (step_reg == 5'd0)
                begin
                    if (rem_reg >= (RW+2)'(r2_reg))
                    begin
                        rem_reg <= rem_reg - (RW+2)'(r2_reg);
                        quo_reg <= 17'd1;
                    end
                end
                else if (rem_sh >= (RW+2)'(r2_reg))
                begin
                    rem_reg <= rem_sh - (RW+2)'(r2_reg);
                    quo_reg <= {quo_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[15:0], 1'b0};
                end
                step_reg <= step_reg + 5'd1;
            end
            ooa_pkg::BK_ACC:
            begin
                aneg_reg <= 1'b0;
                astep_reg <= '0;
                arem_reg <= '0;
                aquo_reg <= '0;
            end
            ooa_pkg::BK_AVG:
            begin
                if (astep_reg == 6'd0)
                begin
                    aneg_reg <= sum_reg[SUM_W-1];
                    amag_reg <= sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
                    astep_reg <= 6'd1;
                end
                else if (astep_reg != 6'(MAG_W + 1))
                begin
                    // signed mean via magnitude long division by the count
                    amag_reg <= {amag_reg[MAG_W-2:0], 1'b0};
                    if (cnt_reg != '0 && arem_sh >= (MAG_W+1)'(cnt_reg))
                    begin
                        arem_reg <= MAG_W'(arem_sh - (MAG_W+1)'(cnt_reg));
                        aquo_reg <= {aquo_reg[MAG_W-2:0], 1'b1};
                    end
                    else
                    begin
                        arem_reg <= MAG_W'(arem_sh);
                        aquo_reg <= {aquo_reg[MAG_W-2:0], 1'b0};
                    end
                    astep_reg <= astep_reg + 6'd1;
                end
            end
            default: ;
        endcase
        if (state_reg == ooa_pkg::BK_AVG && astep_reg == 6'(MAG_W + 1))
        begin
            out_reg.order_value <= (cnt_reg == '0) ? '0 : ooa_pkg::ORDER_WIDTH'(avg_s);
            out_reg.item_count <= ooa_pkg::COUNT_OUT_WIDTH'(cnt_reg);
            out_reg.degenerate_seen <= deg_reg;
        end
    end

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ITEMS)) else $error("count beyond cap");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == ooa_pkg::BK_MUL) else $error("pop without start");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready) |=> cnt_reg == '0 && !deg_reg)
        else $error("state not cleared after result");
`endif
endmodule

// ===== rtl/orientational_order_accumulator_unit.sv =====
// orientational_order_accumulator_unit: top level, mode register, front and back
// depends on ooa_pkg, ooa_stream_if, ooa_front, ooa_back
// order: after its transfer an item passes queue pop, cross product, squares,
// a 17-step divider and accumulate; an item marked last then runs the mean
// division before its result is offered.
// flow: the back end pops no new item until the last is accumulated and any result taken.
// reset: rst_n async low clears mode, sum, count, degenerate flag and queue.
module orientational_order_accumulator_unit #(
    parameter int COORD_WIDTH = 16,
    parameter int MAX_ITEMS = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    ooa_stream_if.sink   in_ch,
    ooa_stream_if.source out_ch
);
    localparam int DW = COORD_WIDTH + 1;

    typedef struct packed {
        logic [1:0]            mode;
        logic                  last;
        logic signed [DW-1:0]  d1, d2, d3, e1, e2, e3;
    } q_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
        logic                          last;
    } in_t;

    typedef struct packed {
        logic signed [17:0] order_value;
        logic [15:0]        item_count;
        logic               degenerate_seen;
    } out_t;

    ooa_pkg::mode_t mode_reg;
    logic q_valid, q_pop;
    q_t   q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= ooa_pkg::MODE_BOND_Z;
        else if (cfg_we)
            mode_reg <= ooa_pkg::mode_t'(cfg_wdata);
    end

    ooa_front #(.COORD_WIDTH(COORD_WIDTH), .IN_T(in_t), .Q_T(q_t)) u_front (
        .clk(clk), .rst_n(rst_n), .mode(mode_reg), .in_ch(in_ch),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
    );

    ooa_back #(.COORD_WIDTH(COORD_WIDTH), .MAX_ITEMS(MAX_ITEMS), .Q_T(q_t),
        .OUT_T(out_t)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
        .q_pop(q_pop), .out_ch(out_ch)
    );
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for orientational_order_accumulator_unit
// depends on ooa_pkg, ooa_stream_if and the unit; predicts the per-set mean of 1.5cos^2-0.5
// from a behavioral model and checks each set result against it

module testbench;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic signed [15:0] bz;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic               last;
    } atom_item_t;

    typedef struct packed {
        logic signed [ooa_pkg::ORDER_WIDTH-1:0] order_value;
        logic [ooa_pkg::COUNT_OUT_WIDTH-1:0]    item_count;
        logic                                   degenerate_seen;
    } order_result_t;

    localparam int MAX_TERMS = 65535;
    localparam int SETTLE_CYCLES = 120;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int LONG_HOLD = 500;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_wdata;

    ooa_stream_if #(.PAYLOAD_T(atom_item_t))    atoms_if ();
    ooa_stream_if #(.PAYLOAD_T(order_result_t)) order_if ();

    orientational_order_accumulator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (atoms_if),
        .out_ch    (order_if)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // behavioral copy of the accumulator
    ooa_pkg::mode_t cur_mode;
    longint        acc_sum;
    int unsigned   acc_count;
    bit            acc_degenerate;
    order_result_t order_expected_q[$];
    atom_item_t    atoms_pending_q[$];

    bit failed;
    bit no_idle;
    int hold_request;

    function automatic logic [127:0] square_mag(longint v);
        logic [127:0] m;
        begin
            m = (v < 0) ? 128'(-v) : 128'(v);
            return m * m;
        end
    endfunction

    function automatic void absorb_atoms(atom_item_t it);
        longint d1, d2, d3, e1, e2, e3, vx, vy, vz, s, c, t, avg;
        logic [127:0] r2, num;
        order_result_t res;
        begin
            d1 = longint'(it.bx) - longint'(it.ax);
            d2 = longint'(it.by) - longint'(it.ay);
            d3 = longint'(it.bz) - longint'(it.az);
            if (cur_mode == ooa_pkg::MODE_BOND_Z)
            begin
                vx = d1; vy = d2; vz = d3;
            end
            else
            begin
                e1 = longint'(it.cx) - longint'(it.ax);
                e2 = longint'(it.cy) - longint'(it.ay);
                e3 = longint'(it.cz) - longint'(it.az);
                vx = d2 * e3 - d3 * e2;
                vy = d3 * e1 - d1 * e3;
                vz = d1 * e2 - d2 * e1;
            end
            s = (cur_mode == ooa_pkg::MODE_RING_X) ? vx :
                (cur_mode == ooa_pkg::MODE_RING_Y) ? vy : vz;
            r2 = square_mag(vx) + square_mag(vy) + square_mag(vz);
            num = square_mag(s);
            if (r2 == 0)
                acc_degenerate = 1'b1;
            else if (acc_count < MAX_TERMS)
            begin
                c = longint'((num << 16) / r2);
                t = 3 * c - 65536;
                acc_sum += (t >>> 1);
                acc_count++;
            end
            if (it.last)
            begin
                avg = (acc_count != 0) ? acc_sum / longint'(acc_count) : 0;
                res.order_value = avg[ooa_pkg::ORDER_WIDTH-1:0];
                res.item_count = acc_count[ooa_pkg::COUNT_OUT_WIDTH-1:0];
                res.degenerate_seen = acc_degenerate;
                order_expected_q.push_back(res);
                acc_sum = 0;
                acc_count = 0;
                acc_degenerate = 1'b0;
            end
        end
    endfunction

    // driver: offers queued items, random gap after each transfer unless no_idle is set
    bit in_took;
    int in_gap;

    always @(posedge clk)
        in_took <= atoms_if.valid && atoms_if.ready;

    always @(negedge clk)
    begin
        logic next_valid;
        if (rst_n)
        begin
            next_valid = atoms_if.valid;
            if (atoms_if.valid && in_took)
            begin
                absorb_atoms(atoms_pending_q.pop_front());
                next_valid = 1'b0;
                in_gap = no_idle ? 0 : $urandom_range(0, 11);
            end
            if (!next_valid)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (atoms_pending_q.size() > 0)
                begin
                    atoms_if.data <= atoms_pending_q[0];
                    next_valid = 1'b1;
                end
            end
            atoms_if.valid <= next_valid;
        end
    end

    // receiver: random stall per result unless no_idle is set, plus one long hold-off on request
    bit out_took;
    int out_wait;

    always @(posedge clk)
        out_took <= order_if.valid && order_if.ready;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request > 0)
            begin
                out_wait = hold_request;
                hold_request = 0;
            end
            if (out_took)
                out_wait = no_idle ? 0 : $urandom_range(0, 11);
            if (out_wait > 0)
            begin
                out_wait--;
                order_if.ready <= 1'b0;
            end
            else
                order_if.ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        order_result_t exp_res;
        if (rst_n && order_if.valid && order_if.ready)
        begin
            if (order_expected_q.size() == 0)
            begin
                $display("%0t: result with none expected: %p", $time, order_if.data);
                failed = 1'b1;
            end
            else
            begin
                exp_res = order_expected_q.pop_front();
                if (order_if.data.order_value !== exp_res.order_value)
                begin
                    $display("%0t: order_value expected %0d actual %0d", $time,
                             exp_res.order_value, order_if.data.order_value);
                    failed = 1'b1;
                end
                if (order_if.data.item_count !== exp_res.item_count)
                begin
                    $display("%0t: item_count expected %0d actual %0d", $time,
                             exp_res.item_count, order_if.data.item_count);
                    failed = 1'b1;
                end
                if (order_if.data.degenerate_seen !== exp_res.degenerate_seen)
                begin
                    $display("%0t: degenerate_seen expected %0b actual %0b", $time,
                             exp_res.degenerate_seen, order_if.data.degenerate_seen);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    int stuck_cycles;

    always @(posedge clk)
    begin
        if ((atoms_if.valid && atoms_if.ready) || (order_if.valid && order_if.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [15:0] random_coord(bit full_range);
        begin
            if (full_range)
                return 16'($urandom_range(0, 65535));
            return 16'($signed($urandom_range(0, 4095)) - 2048);
        end
    endfunction

    function automatic atom_item_t make_atoms(logic [15:0] a, logic [15:0] b,
                                              logic [15:0] cc, bit last);
        atom_item_t it;
        begin
            it.ax = a; it.ay = a; it.az = a;
            it.bx = b; it.by = b; it.bz = b;
            it.cx = cc; it.cy = cc; it.cz = cc;
            it.last = last;
            return it;
        end
    endfunction

    function automatic atom_item_t random_atoms(bit last);
        atom_item_t it;
        bit full_range;
        begin
            full_range = ($urandom_range(0, 3) == 0);
            it.ax = random_coord(full_range);
            it.ay = random_coord(full_range);
            it.az = random_coord(full_range);
            it.bx = random_coord(full_range);
            it.by = random_coord(full_range);
            it.bz = random_coord(full_range);
            it.cx = random_coord(full_range);
            it.cy = random_coord(full_range);
            it.cz = random_coord(full_range);
            case ($urandom_range(0, 19))
                0: {it.bx, it.by, it.bz} = {it.ax, it.ay, it.az};  // zero bond
                1: {it.cx, it.cy, it.cz} = {it.ax, it.ay, it.az};  // collinear ring
                default: ;
            endcase
            it.last = last;
            return it;
        end
    endfunction

    task automatic write_mode(ooa_pkg::mode_t m);
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= m;
            cur_mode = m;
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic drain_block;
        begin
            wait (atoms_pending_q.size() == 0 && !atoms_if.valid &&
                  order_expected_q.size() == 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic queue_random_sets(int n_items, bit close_last);
        int set_left;
        begin
            set_left = $urandom_range(1, 12);
            for (int k = 0; k < n_items; k++)
            begin
                set_left--;
                atoms_pending_q.push_back(random_atoms(set_left == 0 ||
                                          (close_last && k == n_items - 1)));
                if (set_left == 0)
                    set_left = $urandom_range(1, 12);
            end
        end
    endtask

    initial
    begin
        ooa_pkg::mode_t phase_mode;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        atoms_if.valid = 1'b0;
        atoms_if.data = '0;
        order_if.ready = 1'b0;
        failed = 1'b0;
        no_idle = 1'b0;
        hold_request = 0;
        in_gap = 0;
        out_wait = 0;
        cur_mode = ooa_pkg::MODE_BOND_Z;
        acc_sum = 0;
        acc_count = 0;
        acc_degenerate = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, zero vectors, empty set, every mode
        atoms_pending_q.push_back(make_atoms(16'h8000, 16'h7fff, 16'h0000, 1'b0));
        atoms_pending_q.push_back(make_atoms(16'h7fff, 16'h8000, 16'h0000, 1'b1));
        atoms_pending_q.push_back(make_atoms(16'h1234, 16'h1234, 16'h0000, 1'b1));
        atoms_pending_q.push_back(make_atoms(16'h0000, 16'h0100, 16'h0200, 1'b0));
        atoms_pending_q.push_back(make_atoms(16'h0000, 16'h0000, 16'h0000, 1'b1));
        atoms_pending_q.push_back(random_atoms(1'b1));
        drain_block();
        for (int m = 1; m < 4; m++)
        begin
            write_mode(ooa_pkg::mode_t'(m));
            atoms_pending_q.push_back(make_atoms(16'h8000, 16'h7fff, 16'h0000, 1'b1));
            atoms_pending_q.push_back(make_atoms(16'h0000, 16'h7fff, 16'h8000, 1'b0));
            atoms_pending_q.push_back(atom_item_t'{16'h0000, 16'h0000, 16'h0000,
                                                   16'h7fff, 16'h0000, 16'h0000,
                                                   16'h0000, 16'h8000, 16'h0000, 1'b1});
            atoms_pending_q.push_back(atom_item_t'{16'h8000, 16'h8000, 16'h8000,
                                                   16'h7fff, 16'h8000, 16'h8000,
                                                   16'h8000, 16'h8000, 16'h7fff, 1'b1});
            drain_block();
        end

        // random phases; sets may stay open across a mode change
        for (int p = 0; p < 10; p++)
        begin
            phase_mode = (p == 0) ? ooa_pkg::MODE_RING_Y :
                         (p == 1) ? ooa_pkg::MODE_BOND_Z :
                         ooa_pkg::mode_t'($urandom_range(0, 3));
            write_mode(phase_mode);
            no_idle = (p == 4 || p == 7);
            if (p == 5)
                hold_request = LONG_HOLD;
            queue_random_sets(90, p == 9 || $urandom_range(0, 1) == 0);
            drain_block();
        end

        if (order_expected_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, order_expected_q.size());
            failed = 1'b1;
        end
        if (!failed)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ooa_pkg.sv
rtl/ooa_stream_if.sv
rtl/ooa_front.sv
rtl/ooa_back.sv
rtl/orientational_order_accumulator_unit.sv
tb/testbench.sv
